// ----- rtl/aat_pkg.sv -----
// shared types, constants and saturation helpers for the affine box transform
package aat_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int Q_W           = 32;
   localparam int ACC_W         = 64;
   localparam int CSR_W         = 64;
   localparam int CSR_IDX_W     = 3;
   localparam int AXES          = 3;

   typedef logic signed [Q_W-1:0]   q_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      q_type [AXES-1:0] m;
      q_type            t;
   } mat_row_type;

   typedef struct packed {
      q_type lo;
      q_type hi;
      logic  ovf;
   } bound_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_XX_XY = 3'd0,
      CSR_XZ_TX = 3'd1,
      CSR_YX_YY = 3'd2,
      CSR_YZ_TY = 3'd3,
      CSR_ZX_ZY = 3'd4,
      CSR_ZZ_TZ = 3'd5
   } csr_index_type;

   localparam acc_type Q_MAX = 64'sh0000_0000_7fff_ffff;
   localparam acc_type Q_MIN = -64'sh0000_0000_8000_0000;

   function automatic logic is_sat(input acc_type v);
      return (v > Q_MAX) || (v < Q_MIN);
   endfunction

   function automatic q_type sat_q(input acc_type v);
      q_type r;
      if (v > Q_MAX) begin
         r = Q_MAX[Q_W-1:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[Q_W-1:0];
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/aat_csr.sv -----
// matrix configuration registers, reset to the identity transform
module aat_csr import aat_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata,
   output mat_row_type [AXES-1:0]   mat
);

   localparam q_type ONE_Q  = q_type'(32'(1) << FRAC_BITS);
   localparam q_type ZERO_Q = '0;

   // each row packs m[2], m[1], m[0], t from the top down
   localparam mat_row_type [AXES-1:0] MAT_RESET = {
      {ONE_Q,  ZERO_Q, ZERO_Q, ZERO_Q},
      {ZERO_Q, ONE_Q,  ZERO_Q, ZERO_Q},
      {ZERO_Q, ZERO_Q, ONE_Q,  ZERO_Q}
   };

   mat_row_type [AXES-1:0] mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_XX_XY: begin
               mat_ff[0].m[0] <= csr_wdata[63:32];
               mat_ff[0].m[1] <= csr_wdata[31:0];
            end
            CSR_XZ_TX: begin
               mat_ff[0].m[2] <= csr_wdata[63:32];
               mat_ff[0].t    <= csr_wdata[31:0];
            end
            CSR_YX_YY: begin
               mat_ff[1].m[0] <= csr_wdata[63:32];
               mat_ff[1].m[1] <= csr_wdata[31:0];
            end
            CSR_YZ_TY: begin
               mat_ff[1].m[2] <= csr_wdata[63:32];
               mat_ff[1].t    <= csr_wdata[31:0];
            end
            CSR_ZX_ZY: begin
               mat_ff[2].m[0] <= csr_wdata[63:32];
               mat_ff[2].m[1] <= csr_wdata[31:0];
            end
            CSR_ZZ_TZ: begin
               mat_ff[2].m[2] <= csr_wdata[63:32];
               mat_ff[2].t    <= csr_wdata[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign mat = mat_ff;

endmodule

// ----- rtl/aat_prod.sv -----
// one matrix row: registered center and extent products, shifted to q format
module aat_prod import aat_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  q_type [AXES-1:0]     c,
   input  q_type [AXES-1:0]     e,
   input  mat_row_type          row,
   output acc_type [AXES-1:0]   pc,
   output acc_type [AXES-1:0]   pe
);

   logic signed [Q_W:0]   mx  [AXES];
   logic signed [Q_W:0]   mag [AXES];
   acc_type               pcf [AXES];
   acc_type               pef [AXES];
   acc_type [AXES-1:0]    pc_in;
   acc_type [AXES-1:0]    pe_in;
   acc_type [AXES-1:0]    pc_ff;
   acc_type [AXES-1:0]    pe_ff;

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         mx[k]    = {row.m[k][Q_W-1], row.m[k]};
         mag[k]   = mx[k][Q_W] ? -mx[k] : mx[k];
         pcf[k]   = $signed(row.m[k]) * $signed(c[k]);
         pef[k]   = mag[k] * $signed(e[k]);
         pc_in[k] = pcf[k] >>> FRAC_BITS;
         pe_in[k] = pef[k] >>> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff <= pc_in;
         pe_ff <= pe_in;
      end
   end

   assign pc = pc_ff;
   assign pe = pe_ff;

endmodule

// ----- rtl/aat_bound.sv -----
// one output axis: center and extent sums, then saturated lower and upper bounds
module aat_bound import aat_pkg::*; (
   input  q_type                t,
   input  acc_type [AXES-1:0]   pc,
   input  acc_type [AXES-1:0]   pe,
   output bound_type            bnd
);

   acc_type nc;
   acc_type ne;
   acc_type lo_w;
   acc_type hi_w;

   always_comb begin
      nc      = $signed(t) + $signed(pc[0]) + $signed(pc[1]) + $signed(pc[2]);
      ne      = $signed(pe[0]) + $signed(pe[1]) + $signed(pe[2]);
      lo_w    = nc - ne;
      hi_w    = nc + ne;
      bnd.lo  = sat_q(lo_w);
      bnd.hi  = sat_q(hi_w);
      bnd.ovf = is_sat(lo_w) | is_sat(hi_w);
   end

endmodule

// ----- rtl/aat_affine_unused_guard.sv -----
// three-stage datapath control: center/extent, products, bounds
module aat_affine_unused_guard import aat_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic rsp_ready,
   output logic req_ready,
   output logic rsp_valid,
   output logic en1,
   output logic en2,
   output logic en3,
   output logic v2
);

   logic v1_ff, v2_ff, v3_ff;

   assign en3 = !v3_ff || rsp_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   assign req_ready = en1;
   assign rsp_valid = v3_ff;
   assign v2        = v2_ff;

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && !rsp_ready |-> !req_ready)
      else $error("pipeline full and stalled but request taken");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted request lost at first stage");

   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      v2_ff && v3_ff && !rsp_ready |=> v2_ff)
      else $error("product stage dropped while result stalled");

endmodule

// ----- rtl/aabb_affine_transform.sv -----
// top level: transformed axis-aligned box bounds through a configured affine matrix
//
// Each request is one box given as min and max per axis in signed fixed point. The block
// returns the bounds of the box after the 3x4 matrix is applied (center mapped through the
// matrix plus translation, half-extent through the absolute matrix), saturated to 32 bits,
// with an overflow flag when any bound saturated. One box is taken every clock cycle unless
// the pipeline is stalled, and its response passes three registered stages: the input stage
// forms center and half-extent, the product stage runs 18 multipliers in parallel, and the
// result stage sums, saturates and holds the response. Back pressure on the response side
// stalls the pipeline only once all three stages are full. The matrix resets to identity;
// write it only while no request is in flight. Writes to indexes above five are ignored.
module aabb_affine_transform import aat_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  q_type                  req_box_min_x,
   input  q_type                  req_box_max_x,
   input  q_type                  req_box_min_y,
   input  q_type                  req_box_max_y,
   input  q_type                  req_box_min_z,
   input  q_type                  req_box_max_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output q_type                  rsp_out_min_x,
   output q_type                  rsp_out_max_x,
   output q_type                  rsp_out_min_y,
   output q_type                  rsp_out_max_y,
   output q_type                  rsp_out_min_z,
   output q_type                  rsp_out_max_z,
   output logic                   rsp_overflow,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   mat_row_type [AXES-1:0] mat;
   q_type [AXES-1:0]       lo_in;
   q_type [AXES-1:0]       hi_in;
   q_type [AXES-1:0]       c_in;
   q_type [AXES-1:0]       e_in;
   q_type [AXES-1:0]       c_ff;
   q_type [AXES-1:0]       e_ff;
   logic signed [Q_W:0]    sum_w [AXES];
   logic signed [Q_W:0]    dif_w [AXES];
   acc_type [AXES-1:0]     pc [AXES];
   acc_type [AXES-1:0]     pe [AXES];
   bound_type [AXES-1:0]   bnd;
   bound_type [AXES-1:0]   bnd_in;
   bound_type [AXES-1:0]   bnd_ff;
   logic                   en1, en2, en3, v2;

   aat_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mat       (mat)
   );

   aat_affine_unused_guard u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .en1       (en1),
      .en2       (en2),
      .en3       (en3),
      .v2        (v2)
   );

   assign lo_in = {req_box_min_z, req_box_min_y, req_box_min_x};
   assign hi_in = {req_box_max_z, req_box_max_y, req_box_max_x};

   // floor halving of 33-bit sum and difference
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         sum_w[k] = $signed(lo_in[k]) + $signed(hi_in[k]);
         dif_w[k] = $signed(hi_in[k]) - $signed(lo_in[k]);
         c_in[k]  = sum_w[k][Q_W:1];
         e_in[k]  = dif_w[k][Q_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         c_ff <= c_in;
         e_ff <= e_in;
      end
   end

   for (genvar r = 0; r < AXES; r++) begin : g_row
      aat_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
         .clock (clock),
         .en    (en2),
         .c     (c_ff),
         .e     (e_ff),
         .row   (mat[r]),
         .pc    (pc[r]),
         .pe    (pe[r])
      );

      aat_bound u_bound (
         .t   (mat[r].t),
         .pc  (pc[r]),
         .pe  (pe[r]),
         .bnd (bnd[r])
      );
   end

   assign bnd_in = bnd;

   always_ff @(posedge clock) begin
      if (en3 && v2) begin
         bnd_ff <= bnd_in;
      end
   end

   assign rsp_out_min_x = bnd_ff[0].lo;
   assign rsp_out_max_x = bnd_ff[0].hi;
   assign rsp_out_min_y = bnd_ff[1].lo;
   assign rsp_out_max_y = bnd_ff[1].hi;
   assign rsp_out_min_z = bnd_ff[2].lo;
   assign rsp_out_max_z = bnd_ff[2].hi;
   assign rsp_overflow  = bnd_ff[0].ovf | bnd_ff[1].ovf | bnd_ff[2].ovf;

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_out_min_x == Q_MAX[Q_W-1:0] || rsp_out_min_x == Q_MIN[Q_W-1:0] ||
         rsp_out_max_x == Q_MAX[Q_W-1:0] || rsp_out_max_x == Q_MIN[Q_W-1:0] ||
         rsp_out_min_y == Q_MAX[Q_W-1:0] || rsp_out_min_y == Q_MIN[Q_W-1:0] ||
         rsp_out_max_y == Q_MAX[Q_W-1:0] || rsp_out_max_y == Q_MIN[Q_W-1:0] ||
         rsp_out_min_z == Q_MAX[Q_W-1:0] || rsp_out_min_z == Q_MIN[Q_W-1:0] ||
         rsp_out_max_z == Q_MAX[Q_W-1:0] || rsp_out_max_z == Q_MIN[Q_W-1:0])
      else $error("overflow flagged with no saturated bound");

   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      v2 && en3 |=> rsp_valid)
      else $error("product stage advanced without a response");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty response stage");

endmodule

// ----- tb/sv/aabb_affine_transform_test.sv -----
// self-checking testbench for the affine box transform: random and corner boxes
`timescale 1ns / 1ps

module aabb_affine_transform_test;
   import aat_pkg::*;

   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_CYCLES     = 64;
   localparam int BOXES_PER_PHASE = 85;
   localparam int PHASES          = 8;
   localparam int DIRECTED_BOXES  = 10;
   localparam int DRAIN_CYCLES    = 6;
   localparam q_type Q_ONE        = 32'sd1 <<< FRAC_BITS_DEF;

   typedef logic [2*AXES-1:0][Q_W-1:0]   box_vec_type;
   typedef logic [2*AXES-1:0][CSR_W-1:0] mat_regs_type;

   typedef struct packed {
      logic [2*AXES-1:0][Q_W-1:0] b;
      logic                       ovf;
   } bounds_type;

   typedef enum int {
      MAT_SMALL,
      MAT_FULL,
      MAT_IDENT_SHIFT,
      MAT_MAX,
      MAT_MIN,
      MAT_ZERO
   } mat_kind_type;

   localparam mat_kind_type PHASE_PLAN [PHASES] = '{
      MAT_SMALL, MAT_SMALL, MAT_FULL, MAT_SMALL,
      MAT_IDENT_SHIFT, MAT_SMALL, MAT_MAX, MAT_ZERO
   };

   class bounds_scoreboard;
      q_type      coef [AXES][AXES];
      q_type      offset [AXES];
      bounds_type expected_q [$];
      int         errors;

      function void load_identity();
         for (int r = 0; r < AXES; r++) begin
            for (int k = 0; k < AXES; k++) begin
               coef[r][k] = (r == k) ? Q_ONE : '0;
            end
            offset[r] = '0;
         end
      endfunction

      function void load_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] v);
         int row;
         if (idx > CSR_ZZ_TZ) return;
         row = idx / 2;
         if (idx[0] == 1'b0) begin
            coef[row][0] = v[63:32];
            coef[row][1] = v[31:0];
         end else begin
            coef[row][2] = v[63:32];
            offset[row]  = v[31:0];
         end
      endfunction

      function logic [Q_W-1:0] saturate(longint v, inout logic ovf);
         if (v > Q_MAX) begin
            ovf = 1'b1;
            return Q_MAX[Q_W-1:0];
         end
         if (v < Q_MIN) begin
            ovf = 1'b1;
            return Q_MIN[Q_W-1:0];
         end
         return v[Q_W-1:0];
      endfunction

      function bounds_type transform(box_vec_type box);
         longint     ctr [AXES];
         longint     half [AXES];
         longint     lo, hi, m, am, nc, ne;
         logic       ovf;
         bounds_type r;
         ovf = 1'b0;
         for (int k = 0; k < AXES; k++) begin
            lo      = longint'($signed(box[2*k]));
            hi      = longint'($signed(box[2*k+1]));
            ctr[k]  = (lo + hi) >>> 1;
            half[k] = (hi - lo) >>> 1;
         end
         for (int row = 0; row < AXES; row++) begin
            nc = longint'(offset[row]);
            ne = 0;
            for (int k = 0; k < AXES; k++) begin
               m  = longint'(coef[row][k]);
               am = (m < 0) ? -m : m;
               nc += (m * ctr[k]) >>> FRAC_BITS_DEF;
               ne += (am * half[k]) >>> FRAC_BITS_DEF;
            end
            r.b[2*row]   = saturate(nc - ne, ovf);
            r.b[2*row+1] = saturate(nc + ne, ovf);
         end
         r.ovf = ovf;
         return r;
      endfunction

      function string field_label(int i);
         case (i)
            0:       return "out_min_x";
            1:       return "out_max_x";
            2:       return "out_min_y";
            3:       return "out_max_y";
            4:       return "out_min_z";
            5:       return "out_max_z";
            default: return "overflow";
         endcase
      endfunction

      function void note_request(box_vec_type box);
         expected_q.push_back(transform(box));
      endfunction

      function void check_response(bounds_type got);
         bounds_type want;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         for (int i = 0; i < 2*AXES; i++) begin
            if (got.b[i] !== want.b[i]) begin
               $error("%s expected %0d got %0d", field_label(i),
                      $signed(want.b[i]), $signed(got.b[i]));
               errors++;
            end
         end
         if (got.ovf !== want.ovf) begin
            $error("%s expected %0d got %0d", field_label(2*AXES), want.ovf, got.ovf);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   q_type                req_box_min_x = '0;
   q_type                req_box_max_x = '0;
   q_type                req_box_min_y = '0;
   q_type                req_box_max_y = '0;
   q_type                req_box_min_z = '0;
   q_type                req_box_max_z = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   q_type                rsp_out_min_x;
   q_type                rsp_out_max_x;
   q_type                rsp_out_min_y;
   q_type                rsp_out_max_y;
   q_type                rsp_out_min_z;
   q_type                rsp_out_max_z;
   logic                 rsp_overflow;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_XX_XY;
   logic [CSR_W-1:0]     csr_wdata = '0;

   bounds_scoreboard boxes;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   bit               hold_request = 1'b0;

   aabb_affine_transform dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic q_type spread(int unsigned span);
      return q_type'(int'($urandom_range(0, 2 * span)) - int'(span));
   endfunction

   function automatic q_type corner();
      case ($urandom_range(4))
         0:       return Q_MIN[Q_W-1:0];
         1:       return Q_MAX[Q_W-1:0];
         2:       return '0;
         3:       return '1;
         default: return 32'sd1;
      endcase
   endfunction

   function automatic box_vec_type directed_box(int idx);
      box_vec_type b;
      q_type       lo, hi;
      for (int k = 0; k < AXES; k++) begin
         case (idx)
            0: begin lo = '0;               hi = '0;               end
            1: begin lo = Q_MIN[Q_W-1:0];   hi = Q_MAX[Q_W-1:0];   end
            2: begin lo = Q_MAX[Q_W-1:0];   hi = Q_MAX[Q_W-1:0];   end
            3: begin lo = Q_MIN[Q_W-1:0];   hi = Q_MIN[Q_W-1:0];   end
            4: begin lo = Q_MAX[Q_W-1:0];   hi = Q_MIN[Q_W-1:0];   end
            5: begin lo = k - 2;            hi = 3 * k + 1;        end
            6: begin lo = Q_ONE;            hi = -Q_ONE;           end
            7: begin lo = 32'h5555_5555;    hi = 32'haaaa_aaaa;    end
            8: begin lo = '1;               hi = '0;               end
            default: begin
               lo = -32'sd163840 * (k + 1);
               hi = 32'sd475136 - k;
            end
         endcase
         b[2*k]   = lo;
         b[2*k+1] = hi;
      end
      return b;
   endfunction

   function automatic box_vec_type rand_box();
      box_vec_type b;
      int unsigned pick;
      q_type       mid, ext;
      pick = $urandom_range(99);
      for (int k = 0; k < AXES; k++) begin
         mid = spread(1 << 26);
         ext = q_type'($urandom_range(0, 1 << 22));
         if (pick < 50) begin
            b[2*k]   = mid - ext;
            b[2*k+1] = mid + ext;
         end else if (pick < 75) begin
            b[2*k]   = $urandom;
            b[2*k+1] = $urandom;
         end else if (pick < 90) begin
            b[2*k]   = corner();
            b[2*k+1] = corner();
         end else begin
            b[2*k]   = mid + ext;
            b[2*k+1] = mid - ext;
         end
      end
      return b;
   endfunction

   function automatic mat_regs_type make_matrix(mat_kind_type kind);
      mat_regs_type regs;
      q_type        ent [AXES][AXES+1];
      for (int r = 0; r < AXES; r++) begin
         for (int k = 0; k <= AXES; k++) begin
            case (kind)
               MAT_SMALL:       ent[r][k] = (k == AXES) ? spread(1 << 26) : spread(1 << 18);
               MAT_FULL:        ent[r][k] = $urandom;
               MAT_IDENT_SHIFT: ent[r][k] = (k == AXES) ? q_type'($urandom) :
                                            (r == k) ? Q_ONE : '0;
               MAT_MAX:         ent[r][k] = Q_MAX[Q_W-1:0];
               MAT_MIN:         ent[r][k] = Q_MIN[Q_W-1:0];
               default:         ent[r][k] = '0;
            endcase
         end
         regs[2*r]   = {ent[r][0], ent[r][1]};
         regs[2*r+1] = {ent[r][2], ent[r][3]};
      end
      return regs;
   endfunction

   // indexes past the last register get random data and must be ignored
   task automatic write_matrix(input mat_regs_type regs);
      logic [CSR_W-1:0] data;
      for (int i = 0; i < (1 << CSR_IDX_W); i++) begin
         data      = (i < 2*AXES) ? regs[i] : {$urandom, $urandom};
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= data;
         @(posedge clock);
         boxes.load_reg(CSR_IDX_W'(i), data);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_box(input box_vec_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_box_min_x <= b[0];
      req_box_max_x <= b[1];
      req_box_min_y <= b[2];
      req_box_max_y <= b[3];
      req_box_min_z <= b[4];
      req_box_max_z <= b[5];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      boxes.note_request(b);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (boxes.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int         hold_left;
      bounds_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.b   = {rsp_out_max_z, rsp_out_min_z, rsp_out_max_y,
                       rsp_out_min_y, rsp_out_max_x, rsp_out_min_x};
            got.ovf = rsp_overflow;
            boxes.check_response(got);
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      boxes = new;
      boxes.load_identity();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corner boxes through the reset identity, then through the most negative matrix
      for (int i = 0; i < DIRECTED_BOXES; i++) send_box(directed_box(i));
      settle();
      write_matrix(make_matrix(MAT_MIN));
      for (int i = 0; i < DIRECTED_BOXES; i++) send_box(directed_box(i));

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_matrix(make_matrix(PHASE_PLAN[p]));
         case (p % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 55; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 55; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         for (int i = 0; i < BOXES_PER_PHASE; i++) begin
            // long response hold-off so the pipeline fills and backs up
            if (p == 4 && i == 20) hold_request = 1'b1;
            send_box(rand_box());
         end
      end
      settle();

      if (boxes.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
